### hw/rtl/assert_macros.svh
// Assertion helpers: clocked, reset-qualified implication checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### hw/rtl/pft_pkg.sv
`default_nettype none

package pft_pkg;

    localparam int INDEX_BITS  = 32;
    localparam int VERTEX_BITS = 32;
    localparam int SIZE_BITS   = 8;

    localparam logic [SIZE_BITS-1:0] MIN_FACE  = 8'd3;
    localparam logic [SIZE_BITS-1:0] QUAD_SIZE = 8'd4;
    localparam logic [SIZE_BITS-1:0] FAN_START = 8'd2;
    localparam logic [SIZE_BITS-1:0] QUAD_LAST = 8'd3;

    localparam logic [1:0] TRI_NONE = 2'd0;
    localparam logic [1:0] TRI_ONE  = 2'd1;
    localparam logic [1:0] TRI_TWO  = 2'd2;

    typedef logic [INDEX_BITS-1:0] t_index;
    typedef logic [SIZE_BITS-1:0]  t_size;

    typedef enum logic [0:0] {
        CFG_SWAP_WINDING = 1'b0,
        CFG_QUAD_PIVOT   = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic swap_winding;
        logic quad_pivot;
    } t_cfg;

    typedef struct packed {
        t_index a;
        t_index b;
        t_index c;
        logic   last;
    } t_tri;

    typedef struct packed {
        logic [1:0] count;
        t_tri       first_tri;
        t_tri       second_tri;
    } t_tri_pair;

    // free room in the output buffer once this cycle's pop is counted
    typedef struct packed {
        logic one;
        logic two;
    } t_room;

    typedef struct packed {
        logic [1:0] count;
    } t_out_status;

endpackage

`default_nettype wire

### hw/rtl/polygon_fan_triangulator.sv
// Polygon fan triangulator. Corners stream in one beat per cycle, each tagged
// with its face's corner count, and come out as fan triangles one beat per
// cycle. A corner is taken every cycle while the output side keeps up; the
// one exception is the fourth corner of a turned quad, which yields two
// triangle beats and so needs both buffer entries free. A corner is held in
// the input register and its triangles are written into a two-entry output
// buffer, whose head is the output. o_in_ready depends combinationally on
// i_out_ready through the room left in that buffer. Configuration writes are
// registered and apply to whichever corner then sits in the input register.
`default_nettype none
`include "assert_macros.svh"

module polygon_fan_triangulator (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [0:0]                       i_cfg_index,
    input  wire logic                             i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [pft_pkg::VERTEX_BITS-1:0]  i_vertex_index,
    input  wire logic [pft_pkg::SIZE_BITS-1:0]    i_face_size,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [pft_pkg::VERTEX_BITS-1:0]       o_tri_a,
    output logic [pft_pkg::VERTEX_BITS-1:0]       o_tri_b,
    output logic [pft_pkg::VERTEX_BITS-1:0]       o_tri_c,
    output logic                                  o_run_last
);

    pft_pkg::t_cfg         cfg;
    pft_pkg::t_room        room;
    pft_pkg::t_tri_pair    pair;
    pft_pkg::t_tri         head;
    pft_pkg::t_out_status  status;
    logic                  push;

    assign o_cfg_ready = 1'b1;

    pft_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pft_corner u_corner (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_vertex_index (i_vertex_index),
        .i_face_size    (i_face_size),
        .i_room         (room),
        .o_push         (push),
        .o_pair         (pair)
    );

    pft_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pair      (pair),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_head      (head),
        .o_status    (status)
    );

    assign o_tri_a    = pft_pkg::VERTEX_BITS'(head.a);
    assign o_tri_b    = pft_pkg::VERTEX_BITS'(head.b);
    assign o_tri_c    = pft_pkg::VERTEX_BITS'(head.c);
    assign o_run_last = head.last;

    `ASSERT_IMPLY(a_buf_bound, i_clk, i_rst_n, 1'b1, status.count <= 2'd2, "output buffer overfilled")
    `ASSERT_IMPLY(a_push_fits, i_clk, i_rst_n, push && pair.count == pft_pkg::TRI_TWO, room.two, "triangle pair pushed without room")
    `ASSERT_NEXT(a_quad_second, i_clk, i_rst_n, o_out_valid && !o_run_last, o_out_valid, "second quad triangle missing")

endmodule

`default_nettype wire

### hw/rtl/pft_cfg.sv
`default_nettype none

module pft_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    input  wire logic [0:0]    i_cfg_index,
    input  wire logic          i_cfg_data,
    output pft_pkg::t_cfg      o_cfg
);

    pft_pkg::t_cfg r_cfg;
    pft_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (pft_pkg::t_cfg_index'(i_cfg_index))
                pft_pkg::CFG_SWAP_WINDING: n_cfg.swap_winding = i_cfg_data;
                pft_pkg::CFG_QUAD_PIVOT:   n_cfg.quad_pivot   = i_cfg_data;
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### hw/rtl/pft_corner.sv
`default_nettype none

module pft_corner (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire pft_pkg::t_cfg                    i_cfg,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [pft_pkg::VERTEX_BITS-1:0]  i_vertex_index,
    input  wire logic [pft_pkg::SIZE_BITS-1:0]    i_face_size,
    input  wire pft_pkg::t_room                   i_room,
    output logic                                  o_push,
    output pft_pkg::t_tri_pair                    o_pair
);

    logic             r_in_valid;
    pft_pkg::t_index  r_vertex;
    pft_pkg::t_size   r_size;

    pft_pkg::t_size   r_pos;
    pft_pkg::t_index  r_first;
    pft_pkg::t_index  r_second;
    pft_pkg::t_index  r_prev;

    pft_pkg::t_size   n_pos;
    pft_pkg::t_tri_pair pair;
    logic             advance;
    logic             accept;
    logic [pft_pkg::SIZE_BITS:0] pos_inc;

    function automatic pft_pkg::t_tri make_tri(input logic swap, input pft_pkg::t_index a,
                                               input pft_pkg::t_index b,
                                               input pft_pkg::t_index c, input logic last);
        pft_pkg::t_tri t;
        t.a    = a;
        t.b    = swap ? c : b;
        t.c    = swap ? b : c;
        t.last = last;
        return t;
    endfunction

    always_comb begin
        pair            = '0;
        pair.count      = pft_pkg::TRI_NONE;
        pair.first_tri  = make_tri(i_cfg.swap_winding, r_first, r_prev, r_vertex, 1'b1);
        pair.second_tri = make_tri(i_cfg.swap_winding, r_vertex, r_second, r_prev, 1'b1);
        if (r_size >= pft_pkg::MIN_FACE && r_pos >= pft_pkg::FAN_START) begin
            if (i_cfg.quad_pivot && r_size == pft_pkg::QUAD_SIZE) begin
                // turned quad: both triangles fan from the fourth corner
                if (r_pos == pft_pkg::QUAD_LAST) begin
                    pair.count     = pft_pkg::TRI_TWO;
                    pair.first_tri = make_tri(i_cfg.swap_winding, r_vertex, r_first,
                                              r_second, 1'b0);
                end
            end else begin
                pair.count = pft_pkg::TRI_ONE;
            end
        end
    end

    always_comb begin
        case (pair.count)
            pft_pkg::TRI_NONE: advance = r_in_valid;
            pft_pkg::TRI_ONE:  advance = r_in_valid && i_room.one;
            pft_pkg::TRI_TWO:  advance = r_in_valid && i_room.two;
            default:           advance = 1'b0;
        endcase
    end

    assign pos_inc = {1'b0, r_pos} + {{pft_pkg::SIZE_BITS{1'b0}}, 1'b1};
    assign n_pos   = (pos_inc >= {1'b0, r_size}) ? '0 : pos_inc[pft_pkg::SIZE_BITS-1:0];

    assign o_in_ready = !r_in_valid || advance;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pos      <= '0;
            r_first    <= '0;
            r_second   <= '0;
            r_prev     <= '0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !advance);
            if (advance) begin
                r_pos  <= n_pos;
                r_prev <= r_vertex;
                if (r_pos == '0) begin
                    r_first <= r_vertex;
                end
                if (r_pos == pft_pkg::SIZE_BITS'(1)) begin
                    r_second <= r_vertex;
                end
            end
        end
    end

    // input beat payload needs no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vertex <= i_vertex_index[pft_pkg::INDEX_BITS-1:0];
            r_size   <= i_face_size;
        end
    end

    assign o_push = advance;
    assign o_pair = pair;

endmodule

`default_nettype wire

### hw/rtl/pft_out.sv
`default_nettype none

module pft_out (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire pft_pkg::t_tri_pair  i_pair,
    output pft_pkg::t_room           o_room,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output pft_pkg::t_tri            o_head,
    output pft_pkg::t_out_status     o_status
);

    logic [1:0]     r_count;
    pft_pkg::t_tri  r_slot0;
    pft_pkg::t_tri  r_slot1;

    logic [1:0]     n_count;
    pft_pkg::t_tri  n_slot0;
    pft_pkg::t_tri  n_slot1;
    logic           pop;
    logic [1:0]     rem;
    logic [1:0]     push_count;

    assign pop        = (r_count != 2'd0) && i_out_ready;
    assign rem        = r_count - {1'b0, pop};
    assign push_count = i_push ? i_pair.count : pft_pkg::TRI_NONE;

    always_comb begin
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        // advance the waiting triangle to the head
        if (pop) begin
            n_slot0 = r_slot1;
        end
        if (push_count != pft_pkg::TRI_NONE) begin
            if (rem == 2'd0) begin
                n_slot0 = i_pair.first_tri;
                n_slot1 = i_pair.second_tri;
            end else begin
                n_slot1 = i_pair.first_tri;
            end
        end
        n_count = rem + push_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_room.one     = (rem != 2'd2);
    assign o_room.two     = (rem == 2'd0);
    assign o_out_valid    = (r_count != 2'd0);
    assign o_head         = r_slot0;
    assign o_status.count = r_count;

endmodule

`default_nettype wire
